>>> rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// ACK RTT estimator package
// Shared status codes and the structs that travel along the slot chain.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_MATCH  = 3'd3,
    ST_MISS   = 3'd4
  } status_e;

  // Lookup beat that walks the slot chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [WordW-1:0] seq;
    logic [WordW-1:0] time_us;
    logic             hit;
    logic             free_seen;
    logic [WordW-1:0] hit_time;
  } tok_t;

  // Broadcast from the controller that changes one slot.
  typedef struct packed {
    logic             store;
    logic             clear;
    logic [WordW-1:0] seq;
    logic [WordW-1:0] time_us;
  } cmt_t;

endpackage

>>> rtl/ack_rtt_estimator.sv
// ----------------------------------------------------------------------------
// ACK RTT estimator
// Tracks outstanding ACK sequence numbers in a chain of slot cells and keeps
// a smoothed round trip time and variance from matching ACK-ACK beats.
// ----------------------------------------------------------------------------
// Flow: each accepted item's lookup beat leaves the head register and walks
// the slot chain one cell per cycle; a new item enters only after the commit,
// which waits while a stalling receiver holds the output register.
// Reset: all slots empty, estimate 100000 us, variance 50000 us, no result
// pending. Slot payloads are not cleared; they are only read when valid.
// ----------------------------------------------------------------------------
module ack_rtt_estimator #(
  parameter int unsigned ACK_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] time_us_i,
  // Result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] sample_rtt_o,
  output logic [31:0] rtt_estimate_o,
  output logic [31:0] rtt_dev_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IdxW = (ACK_SLOTS > 1) ? $clog2(ACK_SLOTS) : 1;
  localparam int unsigned W    = art_pkg::WordW;

  localparam logic [0:0] CfgInitRtt = 1'b0;
  localparam logic [0:0] CfgInitVar = 1'b1;

  // The controller has three phases: waiting for an item, waiting for the
  // lookup beat to leave the last cell, and committing the result.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_d, state_q;

  // Lookup beat pipeline: entry 0 is the head register, entry i+1 is the
  // output register of cell i.
  art_pkg::tok_t   tok      [ACK_SLOTS+1];
  logic [IdxW-1:0] hit_idx  [ACK_SLOTS+1];
  logic [IdxW-1:0] free_idx [ACK_SLOTS+1];
  logic [ACK_SLOTS:0] tok_vld;

  art_pkg::tok_t   head_q;
  art_pkg::cmt_t   cmt;
  logic [IdxW-1:0] cmt_idx;

  // Captured outcome of the lookup, held until the result can be committed.
  art_pkg::status_e fin_status_q;
  logic [W-1:0]     fin_sample_q;
  logic [W-1:0]     fin_diff_q;
  logic             fin_store_q;
  logic             fin_clear_q;
  logic [IdxW-1:0]  fin_idx_q;
  logic [W-1:0]     fin_seq_q;
  logic [W-1:0]     fin_time_q;

  logic [W-1:0] rtt_q, var_q;
  logic [W-1:0] rtt_upd, var_upd;
  logic [W-1:0] rtt_next, var_next;

  logic             out_valid_q;
  art_pkg::status_e out_status_q;
  logic [W-1:0]     out_sample_q, out_rtt_q, out_var_q;

  logic             in_accept;
  logic             out_free;
  logic             scan_done;
  logic             commit;
  art_pkg::tok_t    end_tok;
  art_pkg::status_e end_status;
  logic [W-1:0]     end_sample;
  logic [W-1:0]     end_diff;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  // Register writes are taken only while no item is in flight, so a write can
  // never collide with the commit of a smoothed estimate.
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // The head register launches one beat per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q.valid     <= in_accept;
      head_q.hit       <= 1'b0;
      head_q.free_seen <= 1'b0;
      head_q.hit_time  <= '0;
      if (in_accept) begin
        head_q.op      <= operation_i;
        head_q.seq     <= seq_i;
        head_q.time_us <= time_us_i;
      end
    end
  end

  assign tok[0]      = head_q;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  // Commit broadcast, taken by the cell whose index matches.
  assign commit       = (state_q == S_FIN) && out_free;
  assign cmt.store    = commit && fin_store_q;
  assign cmt.clear    = commit && fin_clear_q;
  assign cmt.seq      = fin_seq_q;
  assign cmt.time_us  = fin_time_q;
  assign cmt_idx      = fin_idx_q;

  for (genvar i = 0; i < ACK_SLOTS; i++) begin : g_cell
    art_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok[i]),
      .hit_idx_i  (hit_idx[i]),
      .free_idx_i (free_idx[i]),
      .tok_o      (tok[i+1]),
      .hit_idx_o  (hit_idx[i+1]),
      .free_idx_o (free_idx[i+1]),
      .cmt_i      (cmt),
      .cmt_idx_i  (cmt_idx)
    );
  end

  for (genvar i = 0; i <= ACK_SLOTS; i++) begin : g_vld
    assign tok_vld[i] = tok[i].valid;
  end

  // When the beat leaves the last cell it knows whether the sequence is
  // held and where the lowest free slot is.
  assign end_tok   = tok[ACK_SLOTS];
  assign scan_done = (state_q == S_SCAN) && end_tok.valid;

  always_comb begin
    end_sample = '0;
    if (!end_tok.op) begin
      if (end_tok.hit) begin
        end_status = art_pkg::ST_DUP;
      end else if (end_tok.free_seen) begin
        end_status = art_pkg::ST_STORED;
      end else begin
        end_status = art_pkg::ST_FULL;
      end
    end else if (end_tok.hit) begin
      end_status = art_pkg::ST_MATCH;
      end_sample = end_tok.time_us - end_tok.hit_time;
    end else begin
      end_status = art_pkg::ST_MISS;
    end
  end

  // Absolute error against the current estimate; the estimate cannot move
  // before this item commits.
  assign end_diff = (rtt_q >= end_sample) ? (rtt_q - end_sample) : (end_sample - rtt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_store_q <= 1'b0;
      fin_clear_q <= 1'b0;
    end else if (scan_done) begin
      fin_store_q <= (end_status == art_pkg::ST_STORED);
      fin_clear_q <= (end_status == art_pkg::ST_MATCH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      fin_status_q <= end_status;
      fin_sample_q <= end_sample;
      fin_diff_q   <= end_diff;
      fin_idx_q    <= end_tok.op ? hit_idx[ACK_SLOTS] : free_idx[ACK_SLOTS];
      fin_seq_q    <= end_tok.seq;
      fin_time_q   <= end_tok.time_us;
    end
  end

  art_update u_update (
    .rtt_i    (rtt_q),
    .var_i    (var_q),
    .sample_i (fin_sample_q),
    .diff_i   (fin_diff_q),
    .rtt_o    (rtt_upd),
    .var_o    (var_upd)
  );

  assign rtt_next = (fin_status_q == art_pkg::ST_MATCH) ? rtt_upd : rtt_q;
  assign var_next = (fin_status_q == art_pkg::ST_MATCH) ? var_upd : var_q;

  // Estimates: loaded by configuration writes, smoothed on a match.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_q <= W'(100000);
      var_q <= W'(50000);
    end else if (commit) begin
      rtt_q <= rtt_next;
      var_q <= var_next;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgInitRtt: rtt_q <= cfg_data_i;
        CfgInitVar: var_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept) state_d = S_SCAN;
      S_SCAN: if (scan_done) state_d = S_FIN;
      S_FIN:  if (out_free)  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register keeps its beat while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= fin_status_q;
      out_sample_q <= fin_sample_q;
      out_rtt_q    <= rtt_next;
      out_var_q    <= var_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign sample_rtt_o   = out_sample_q;
  assign rtt_estimate_o = out_rtt_q;
  assign rtt_dev_o      = out_var_q;

  // At most one lookup beat is ever in the chain.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one lookup beat in the slot chain");

  // A beat leaves the last cell only while the controller waits for it.
  a_end_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_tok.valid |-> (state_q == S_SCAN))
    else $error("lookup beat finished outside the scan phase");

  // A commit never both fills and frees a slot.
  a_cmt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmt.store && cmt.clear))
    else $error("commit both stores and clears a slot");

  // A new result appears only right after a commit.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised without a commit");

endmodule

>>> rtl/art_cell.sv
// ----------------------------------------------------------------------------
// ACK RTT estimator slot cell
// Holds one outstanding sequence number and its send time, checks the passing
// lookup beat against it and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module art_cell #(
  parameter int unsigned IdxW    = 5,
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  art_pkg::tok_t       tok_i,
  input  logic [IdxW-1:0]     hit_idx_i,
  input  logic [IdxW-1:0]     free_idx_i,
  output art_pkg::tok_t       tok_o,
  output logic [IdxW-1:0]     hit_idx_o,
  output logic [IdxW-1:0]     free_idx_o,
  input  art_pkg::cmt_t       cmt_i,
  input  logic [IdxW-1:0]     cmt_idx_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic                      valid_q;
  logic [art_pkg::WordW-1:0] seq_q;
  logic [art_pkg::WordW-1:0] time_q;

  art_pkg::tok_t   tok_d, tok_q;
  logic [IdxW-1:0] hit_idx_d, hit_idx_q;
  logic [IdxW-1:0] free_idx_d, free_idx_q;
  logic            hit_here;
  logic            sel;

  assign hit_here = valid_q && (seq_q == tok_i.seq);
  assign sel      = (cmt_idx_i == MyIdx);

  // The first matching cell and the first empty cell along the chain win.
  always_comb begin
    tok_d      = tok_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    if (!tok_i.hit && hit_here) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_time = time_q;
      hit_idx_d      = MyIdx;
    end
    if (!tok_i.free_seen && !valid_q) begin
      tok_d.free_seen = 1'b1;
      free_idx_d      = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (sel && cmt_i.store) begin
        valid_q <= 1'b1;
      end else if (sel && cmt_i.clear) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (sel && cmt_i.store) begin
      seq_q  <= cmt_i.seq;
      time_q <= cmt_i.time_us;
    end
  end

  assign tok_o      = tok_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

>>> rtl/art_update.sv
// ----------------------------------------------------------------------------
// ACK RTT estimator smoothing update
// New variance (3*var + diff)/4 and new estimate (7*rtt + sample)/8.
// ----------------------------------------------------------------------------
module art_update (
  input  logic [art_pkg::WordW-1:0] rtt_i,
  input  logic [art_pkg::WordW-1:0] var_i,
  input  logic [art_pkg::WordW-1:0] sample_i,
  input  logic [art_pkg::WordW-1:0] diff_i,
  output logic [art_pkg::WordW-1:0] rtt_o,
  output logic [art_pkg::WordW-1:0] var_o
);

  logic [art_pkg::WordW+1:0] var_sum;
  logic [art_pkg::WordW+2:0] rtt_sum;

  // Multiplications by 3 and 7 are done as shift and add or subtract.
  assign var_sum = {1'b0, var_i, 1'b0} + {2'b00, var_i} + {2'b00, diff_i};
  assign rtt_sum = {rtt_i, 3'b000} - {3'b000, rtt_i} + {3'b000, sample_i};

  assign var_o = var_sum[art_pkg::WordW+1:2];
  assign rtt_o = rtt_sum[art_pkg::WordW+2:3];

endmodule

>>> bench/ack_rtt_estimator_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACK RTT estimator checker
// Watches the item, result and register channels of the estimator, keeps its
// own copy of the slot table and the smoothed estimates, and compares every
// result beat field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module ack_rtt_estimator_chk #(
  parameter int unsigned ACK_SLOTS = 32,
  parameter logic        OpAckAck  = 1'b1,
  parameter logic [0:0]  RttReg    = 1'b0,
  parameter logic [0:0]  RttVarReg = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] time_us_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] sample_rtt_i,
  input  logic [31:0] rtt_estimate_i,
  input  logic [31:0] rtt_dev_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [31:0] ResetRtt    = 32'd100000;
  localparam logic [31:0] ResetRttVar = 32'd50000;

  typedef struct packed {
    art_pkg::status_e status;
    logic [31:0]      sample_rtt;
    logic [31:0]      rtt_estimate;
    logic [31:0]      rtt_dev;
  } ack_result_t;

  logic        slot_held [ACK_SLOTS];
  logic [31:0] slot_seq  [ACK_SLOTS];
  logic [31:0] slot_time [ACK_SLOTS];
  logic [31:0] est_rtt;
  logic [31:0] est_rtt_var;
  ack_result_t expected_results [$];
  int unsigned fail_count = 0;

  assign fail_count_o = fail_count;

  // Table lookup and estimator update for one accepted item.
  task automatic predict_item(input logic op, input logic [31:0] seq,
                              input logic [31:0] stamp, output ack_result_t res);
    int          hit;
    int          free_slot;
    logic [31:0] diff;
    logic [33:0] var_sum;
    logic [34:0] rtt_sum;
    hit = -1;
    free_slot = -1;
    for (int i = ACK_SLOTS - 1; i >= 0; i--) begin
      if (slot_held[i] && slot_seq[i] == seq) hit = i;
      if (!slot_held[i]) free_slot = i;
    end
    res.sample_rtt = '0;
    if (op != OpAckAck) begin
      if (hit >= 0) begin
        res.status = art_pkg::ST_DUP;
      end else if (free_slot < 0) begin
        res.status = art_pkg::ST_FULL;
      end else begin
        slot_held[free_slot] = 1'b1;
        slot_seq[free_slot]  = seq;
        slot_time[free_slot] = stamp;
        res.status = art_pkg::ST_STORED;
      end
    end else if (hit < 0) begin
      res.status = art_pkg::ST_MISS;
    end else begin
      res.sample_rtt = stamp - slot_time[hit];
      diff = (est_rtt >= res.sample_rtt) ? est_rtt - res.sample_rtt
                                         : res.sample_rtt - est_rtt;
      // The variance uses the estimate from before this sample.
      var_sum = {2'b00, est_rtt_var} * 3 + {2'b00, diff};
      rtt_sum = {3'b000, est_rtt} * 7 + {3'b000, res.sample_rtt};
      est_rtt_var = var_sum[33:2];
      est_rtt     = rtt_sum[34:3];
      slot_held[hit] = 1'b0;
      res.status = art_pkg::ST_MATCH;
    end
    res.rtt_estimate = est_rtt;
    res.rtt_dev      = est_rtt_var;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ack_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ACK_SLOTS; i++) slot_held[i] = 1'b0;
      est_rtt     = ResetRtt;
      est_rtt_var = ResetRttVar;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d, estimate %0d",
                 status_i, rtt_estimate_i);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("sample_rtt", want.sample_rtt, sample_rtt_i);
          check_field("rtt_estimate", want.rtt_estimate, rtt_estimate_i);
          check_field("rtt_dev", want.rtt_dev, rtt_dev_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RttReg) est_rtt = cfg_data_i;
        else if (cfg_index_i == RttVarReg) est_rtt_var = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_item(operation_i, seq_i, time_us_i, want);
        expected_results = {expected_results, want};
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> bench/ack_rtt_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACK RTT estimator testbench
// Drives register and ack-ack beats into the estimator under several register
// settings and idle patterns, while a checker beside the block predicts every
// result and compares it. A short directed run comes first, then mostly
// well-formed register/ack-ack pairs mixed with duplicates, misses and floods
// that fill the table.
// ----------------------------------------------------------------------------
module ack_rtt_estimator_tb;

  localparam int unsigned ACK_SLOTS = 32;
  // Register indexes and operation codes of the item and register channels.
  localparam logic [0:0]  RegInitRtt    = 1'b0;
  localparam logic [0:0]  RegInitRttVar = 1'b1;
  localparam logic        OpRegister    = 1'b0;
  localparam logic        OpAckAck      = 1'b1;
  // Items per random phase; four phases give roughly 1250 items in total.
  localparam int unsigned PhaseItems    = 312;
  // Cycles without any accepted beat before the run is declared hung. The
  // slowest legal gap is the block latency plus a long stall or idle run.
  localparam int unsigned QuietLimit    = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OpRegister;
  logic [31:0] seq_i       = '0;
  logic [31:0] time_us_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] sample_rtt_o;
  logic [31:0] rtt_estimate_o;
  logic [31:0] rtt_dev_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = RegInitRtt;
  logic [31:0] cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending_results;

  // Percent chances of a sender gap and of a receiver stall in each cycle.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Sequence numbers the block should be holding right now, with their send
  // times. This only shapes the stimulus; the checker does the predicting.
  logic [31:0] held_seq  [$];
  logic [31:0] held_time [$];
  logic [31:0] now_us = 32'd1000;

  ack_rtt_estimator #(
    .ACK_SLOTS(ACK_SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .seq_i         (seq_i),
    .time_us_i     (time_us_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .sample_rtt_o  (sample_rtt_o),
    .rtt_estimate_o(rtt_estimate_o),
    .rtt_dev_o     (rtt_dev_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ack_rtt_estimator_chk #(
    .ACK_SLOTS(ACK_SLOTS),
    .OpAckAck (OpAckAck),
    .RttReg   (RegInitRtt),
    .RttVarReg(RegInitRttVar)
  ) rtt_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .operation_i   (operation_i),
    .seq_i         (seq_i),
    .time_us_i     (time_us_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .sample_rtt_i  (sample_rtt_o),
    .rtt_estimate_i(rtt_estimate_o),
    .rtt_dev_i     (rtt_dev_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls at random, at the rate the current phase sets.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: any accepted beat on any channel shows the block is alive.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int find_held(input logic [31:0] seq);
    for (int i = 0; i < held_seq.size(); i++) begin
      if (held_seq[i] == seq) return i;
    end
    return -1;
  endfunction

  // Offers one item beat, possibly after a random gap, and waits until the
  // block takes it. Valid is left high so the next beat can follow at once.
  task automatic send_item(input logic op, input logic [31:0] seq,
                           input logic [31:0] stamp);
    int idx;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    seq_i       <= seq;
    time_us_i   <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    idx = find_held(seq);
    if (op == OpRegister && idx < 0 && held_seq.size() < ACK_SLOTS) begin
      held_seq  = {held_seq, seq};
      held_time = {held_time, stamp};
    end else if (op == OpAckAck && idx >= 0) begin
      held_seq.delete(idx);
      held_time.delete(idx);
    end
  endtask

  // Holds the sender back until every outstanding result has come out. The
  // extra edge lets the checker's count catch up with the last accepted beat.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // Loads both estimates while the block is idle.
  task automatic load_estimates(input logic [31:0] rtt, input logic [31:0] rtt_var);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegInitRtt;
    cfg_data_i  <= rtt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= RegInitRttVar;
    cfg_data_i  <= rtt_var;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly realistic round trips, some tiny ones, and now and then any value
  // at all so that the sample wraps.
  function automatic logic [31:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 400000);
    if (r < 95) return $urandom_range(0, 20);
    return $urandom;
  endfunction

  task automatic register_fresh();
    if ($urandom_range(0, 99) < 95) now_us = now_us + $urandom_range(0, 5000);
    else now_us = $urandom;
    send_item(OpRegister, $urandom, now_us);
  endtask

  // One random step. Most steps are well-formed register and ack-ack pairs;
  // the rest are duplicates, unknown acks, floods that fill the table past
  // full, and bursts that acknowledge the oldest entries.
  task automatic random_action();
    int unsigned pick;
    int          k;
    int          n;
    pick = $urandom_range(0, 99);
    if (held_seq.size() == 0 && ((pick >= 40 && pick < 85) || pick >= 97)) pick = 0;
    if (pick < 40) begin
      register_fresh();
    end else if (pick < 75) begin
      k = $urandom_range(0, held_seq.size() - 1);
      send_item(OpAckAck, held_seq[k], held_time[k] + pick_delay());
    end else if (pick < 85) begin
      k = $urandom_range(0, held_seq.size() - 1);
      send_item(OpRegister, held_seq[k], $urandom);
    end else if (pick < 93) begin
      send_item(OpAckAck, $urandom, $urandom);
    end else if (pick < 97) begin
      n = ACK_SLOTS - held_seq.size() + $urandom_range(1, 3);
      repeat (n) register_fresh();
    end else begin
      n = $urandom_range(1, held_seq.size());
      repeat (n) send_item(OpAckAck, held_seq[0], held_time[0] + pick_delay());
    end
  endtask

  task automatic run_phase(input int unsigned send_idle, input int unsigned recv_stall,
                           input logic [31:0] rtt, input logic [31:0] rtt_var);
    int unsigned target;
    load_estimates(rtt, rtt_var);
    idle_pct = send_idle;
    stall_pct <= recv_stall;
    target = items_sent + PhaseItems;
    while (items_sent < target) begin
      // Occasionally let the pipeline run completely dry mid-phase.
      if ($urandom_range(0, 99) == 0) wait_drained();
      random_action();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset estimates: extreme sequence numbers and
    // times, a duplicate that keeps its old time, an unknown ack, a freed
    // entry acknowledged twice, a clock that wraps forward, a time that
    // looks earlier than the send time, and a zero sample.
    send_item(OpRegister, 32'h0000_0000, 32'h0000_0000);
    send_item(OpRegister, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_item(OpRegister, 32'h0000_0000, 32'd777);
    send_item(OpAckAck,   32'h0000_0001, 32'hFFFF_FFFF);
    send_item(OpAckAck,   32'h0000_0000, 32'd100000);
    send_item(OpAckAck,   32'h0000_0000, 32'd100001);
    send_item(OpAckAck,   32'hFFFF_FFFF, 32'h0000_0010);
    send_item(OpRegister, 32'h0000_0005, 32'd1000);
    send_item(OpAckAck,   32'h0000_0005, 32'd999);
    send_item(OpRegister, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_item(OpAckAck,   32'h5A5A_5A5A, 32'hA5A5_A5A5);

    // Random phases, each with its own register setting and idle pattern.
    run_phase(0, 0, 32'h0000_0000, 32'h0000_0000);
    run_phase(63, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(0, 63, $urandom, $urandom);
    run_phase(35, 35, 32'd100000, 32'd50000);

    wait_drained();
    repeat (ACK_SLOTS + 4) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
